/* hdl/bicu_pkg.sv */
// Shared constants, types and helper functions for the bone id compaction table.
// Used by the lane, merge and top-level modules; no dependencies of its own.
`default_nettype none

package bicu_pkg;

  localparam int TABLE_SLOTS  = 128;
  // Lane count must be a power of two and at least three, so that the three
  // consecutive slots one vertex can claim always land in different lanes.
  localparam int LANES        = 16;
  localparam int ROWS         = (TABLE_SLOTS + LANES - 1) / LANES;
  localparam int INFL         = 3;
  localparam int ID_W         = 16;
  localparam int FRAC_W       = 16;
  localparam int SLOT_FIELD_W = 7;
  localparam int LANE_W       = $clog2(LANES);
  localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FILL_W       = $clog2(TABLE_SLOTS + 1);
  localparam int CMP_W        = ROW_W + LANE_W + FILL_W;
  localparam int IN_DATA_W    = 2 * INFL * 16;
  localparam int OUT_DATA_W   = ((INFL * (SLOT_FIELD_W + FRAC_W) + 1 + 7) / 8) * 8;
  localparam int OUT_USED_W   = INFL * (SLOT_FIELD_W + FRAC_W) + 1;

  // floor(0.9999 * 65536)
  localparam logic [FRAC_W-1:0] FRAC_MAX = 16'd65529;

  typedef logic [ID_W-1:0]         id_t;
  typedef logic [FRAC_W-1:0]       frac_t;
  typedef logic [ROW_W-1:0]        row_t;
  typedef logic [LANE_W-1:0]       lane_idx_t;
  typedef logic [FILL_W-1:0]       fill_t;
  typedef logic [SLOT_FIELD_W-1:0] slot_field_t;

  typedef struct packed {
    logic clear;
    logic rd_en;
    row_t rd_row;
  } lane_ctrl_t;

  typedef struct packed {
    logic en;
    row_t row;
    id_t  id;
  } lane_wr_t;

  typedef struct packed {
    logic [INFL-1:0] hit;
    row_t [INFL-1:0] row;
  } lane_res_t;

  typedef struct packed {
    fill_t [INFL-1:0] slot;
    logic  [INFL-1:0] ins;
    fill_t            fill_new;
    logic             overflow;
  } mrg_t;

  function automatic frac_t clamp_frac(frac_t w);
    return (w > FRAC_MAX) ? FRAC_MAX : w;
  endfunction

  // Slot number of a lane entry; slot = row * LANES + lane.
  function automatic fill_t slot_num(row_t r, lane_idx_t l);
    logic [CMP_W-1:0] s;
    s = {{FILL_W{1'b0}}, r, l};
    return s[FILL_W-1:0];
  endfunction

  function automatic row_t slot_row(fill_t s);
    logic [FILL_W+ROW_W-1:0] w;
    w = {{ROW_W{1'b0}}, s} >> LANE_W;
    return w[ROW_W-1:0];
  endfunction

  function automatic lane_idx_t slot_lane(fill_t s);
    logic [FILL_W+LANE_W-1:0] w;
    w = {{LANE_W{1'b0}}, s};
    return w[LANE_W-1:0];
  endfunction

  function automatic slot_field_t slot_field(fill_t s);
    logic [FILL_W+SLOT_FIELD_W-1:0] w;
    w = {{SLOT_FIELD_W{1'b0}}, s};
    return w[SLOT_FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/bicu_lane.sv */
// One lane of the slot table: a bank of ids for slots lane, lane+LANES, ...
// and the compare logic that records where each of the three keys hit. Uses bicu_pkg.
`default_nettype none

module bicu_lane import bicu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  lane_idx_t        lane_idx,
  input  lane_ctrl_t       ctrl,
  input  lane_wr_t         wr,
  input  id_t [INFL-1:0]   keys,
  input  fill_t            fill,
  output lane_res_t        res
);

  id_t  bank [ROWS];
  id_t  rd_data;
  row_t rd_row_q;
  logic cmp_valid;
  logic entry_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      bank[wr.row] <= wr.id;
    end
    if (ctrl.rd_en) begin
      rd_data <= bank[ctrl.rd_row];
    end
    rd_row_q <= ctrl.rd_row;
  end

  // Only slots below the fill count hold ids; the compare is done wide so
  // that padding rows past the table never look valid.
  assign entry_valid = ({{FILL_W{1'b0}}, rd_row_q, lane_idx} < CMP_W'(fill));

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      res.hit   <= '0;
    end else begin
      cmp_valid <= ctrl.rd_en;
      if (ctrl.clear) begin
        res.hit <= '0;
      end else if (cmp_valid && entry_valid) begin
        for (int k = 0; k < INFL; k++) begin
          if (rd_data == keys[k]) begin
            res.hit[k] <= 1'b1;
            res.row[k] <= rd_row_q;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/bicu_merge.sv */
// Merging stage: combines the lane hits into slot numbers and resolves the
// inserts of one vertex in the order a, b, c. Uses bicu_pkg.
`default_nettype none

module bicu_merge import bicu_pkg::*; (
  input  lane_res_t      res [LANES],
  input  id_t [INFL-1:0] ids,
  input  fill_t          fill,
  output mrg_t           mrg
);

  logic  [INFL-1:0] found;
  fill_t [INFL-1:0] fslot;
  fill_t            fill_run;
  logic             dup;

  always_comb begin
    found    = '0;
    fslot    = '0;
    fill_run = fill;
    dup      = 1'b0;
    mrg      = '0;

    // Table ids are distinct, so at most one lane hits per key.
    for (int l = 0; l < LANES; l++) begin
      for (int k = 0; k < INFL; k++) begin
        if (res[l].hit[k]) begin
          found[k] = 1'b1;
          fslot[k] = fslot[k] | slot_num(res[l].row[k], lane_idx_t'(l));
        end
      end
    end

    // A key missed by the scan may still match an id inserted by an
    // earlier influence of the same vertex.
    for (int k = 0; k < INFL; k++) begin
      if (found[k]) begin
        mrg.slot[k] = fslot[k];
      end else begin
        dup = 1'b0;
        for (int j = 0; j < k; j++) begin
          if (mrg.ins[j] && (ids[j] == ids[k])) begin
            dup         = 1'b1;
            mrg.slot[k] = mrg.slot[j];
          end
        end
        if (!dup) begin
          if (fill_run < FILL_W'(TABLE_SLOTS)) begin
            mrg.slot[k] = fill_run;
            mrg.ins[k]  = 1'b1;
            fill_run    = fill_run + fill_t'(1);
          end else begin
            mrg.overflow = 1'b1;
          end
        end
      end
    end
    mrg.fill_new = fill_run;
  end

endmodule

`default_nettype wire

/* hdl/bone_id_compaction_table_unit.sv */
// Top level of the bone id compaction table: stream ports, scan sequencer,
// lane banks and output register. Uses bicu_pkg, bicu_lane and bicu_merge.
//
// Each item is one skinned vertex with three bone influences. The unit maps
// every bone id to a compact slot in first-seen order and clamps each weight
// to 65529. A vertex passes through a scan of every row of the lane banks, in
// which every lane reads one entry a cycle from its own memory and compares it
// against all three ids, a drain state for the last compare, a merge state
// that writes back new ids and also loads the result, and an idle state in
// which the next item is taken. The result waits in an output register, so
// the next vertex is taken while it is unread; that vertex then waits in its
// merge state until the register is free. The table needs no clearing after
// reset: only slots below the fill count are valid, and a vertex with the
// start flag set empties the table first.
`default_nettype none

module bone_id_compaction_table_unit import bicu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // bone_id_a, weight_a, bone_id_b, weight_b, bone_id_c, weight_c
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // start_of_mesh
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // slot_a, frac_a, slot_b, frac_b, slot_c, frac_c, overflow, zero padding
  output logic [OUT_DATA_W-1:0] m_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RESOLVE
  } state_t;

  state_t           state;
  row_t             row_cnt;
  fill_t            fill;
  id_t   [INFL-1:0] ids;
  frac_t [INFL-1:0] wts;
  lane_ctrl_t       lane_ctrl;
  lane_wr_t         lane_wr  [LANES];
  lane_res_t        lane_res [LANES];
  mrg_t             mrg;
  logic             load;
  logic             accept;
  logic [OUT_USED_W-1:0] out_word;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load     = (state == S_RESOLVE) && (!m_tvalid || m_tready);

  assign lane_ctrl.clear  = accept;
  assign lane_ctrl.rd_en  = (state == S_SCAN);
  assign lane_ctrl.rd_row = row_cnt;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    bicu_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .lane_idx (lane_idx_t'(l)),
      .ctrl     (lane_ctrl),
      .wr       (lane_wr[l]),
      .keys     (ids),
      .fill     (fill),
      .res      (lane_res[l])
    );
  end

  bicu_merge u_merge (
    .res  (lane_res),
    .ids  (ids),
    .fill (fill),
    .mrg  (mrg)
  );

  // New slots of one vertex are consecutive, so each lane takes at most one write.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_wr[l] = '0;
      for (int k = 0; k < INFL; k++) begin
        if (load && mrg.ins[k] && (slot_lane(mrg.slot[k]) == lane_idx_t'(l))) begin
          lane_wr[l].en  = 1'b1;
          lane_wr[l].row = slot_row(mrg.slot[k]);
          lane_wr[l].id  = ids[k];
        end
      end
    end
  end

  assign out_word = {mrg.overflow,
                     clamp_frac(wts[2]), slot_field(mrg.slot[2]),
                     clamp_frac(wts[1]), slot_field(mrg.slot[1]),
                     clamp_frac(wts[0]), slot_field(mrg.slot[0])};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      row_cnt  <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int k = 0; k < INFL; k++) begin
              ids[k] <= s_tdata[32*k +: 16];
              wts[k] <= s_tdata[32*k+16 +: 16];
            end
            if (s_tuser[0]) begin
              fill <= '0;
            end
            row_cnt <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (row_cnt == row_t'(ROWS - 1)) begin
            state <= S_DRAIN;
          end else begin
            row_cnt <= row_cnt + row_t'(1);
          end
        end
        S_DRAIN: begin
          state <= S_RESOLVE;
        end
        S_RESOLVE: begin
          if (load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DATA_W'(out_word);
            fill     <= mrg.fill_new;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TABLE_SLOTS))
    else $error("fill count exceeds table size");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser[0]) |=> (fill == '0))
    else $error("start of mesh did not empty the table");

  a_fill_tracks_inserts: assert property (@(posedge clk) disable iff (rst)
    load |-> (mrg.fill_new == fill + FILL_W'($countones(mrg.ins))))
    else $error("fill count does not match number of inserts");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (load && mrg.overflow) |-> (mrg.fill_new == FILL_W'(TABLE_SLOTS)))
    else $error("overflow reported while table has free slots");

endmodule

`default_nettype wire
